/* hw/rtl/i32div_pkg.sv */
// Shared types and constants for the 32-bit integer divider.
`timescale 1ns / 1ps

package i32div_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CELL_W     = 8;
   localparam int N_CELLS    = DATA_WIDTH / CELL_W;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   localparam logic [DATA_WIDTH-1:0] DW_SIGN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] DW_MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DW_ONES   = {DATA_WIDTH{1'b1}};

   typedef struct packed {
      logic                  opcode;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
      logic                  div_by_zero;
   } div_rsp_type;

   // Control shared by every cell of the row.
   typedef struct packed {
      logic load;
      logic step;
      logic take;
   } cell_ctrl_type;

endpackage

/* hw/rtl/i32div_cell.sv */
// One slice of the divider row: partial remainder, dividend/quotient and divisor bits.
`timescale 1ns / 1ps

module i32div_cell
   import i32div_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [CELL_W-1:0] ld_qd,
   input  logic [CELL_W-1:0] ld_dvs,
   input  logic              rem_in,
   input  logic              qd_in,
   input  logic              borrow_in,
   output logic              rem_msb,
   output logic              qd_msb,
   output logic              borrow_out,
   output logic [CELL_W-1:0] rem,
   output logic [CELL_W-1:0] qd
);

   logic [CELL_W-1:0] rem_ff, rem_in_v;
   logic [CELL_W-1:0] qd_ff, qd_in_v;
   logic [CELL_W-1:0] dvs_ff, dvs_in;
   logic [CELL_W-1:0] rem_sh;
   logic [CELL_W:0]   diff;

   always_comb begin
      rem_sh = {rem_ff[CELL_W-2:0], rem_in};
      diff   = {1'b0, rem_sh} - {1'b0, dvs_ff} - {{CELL_W{1'b0}}, borrow_in};
   end

   always_comb begin
      rem_in_v = rem_ff;
      qd_in_v  = qd_ff;
      dvs_in   = dvs_ff;
      if (ctrl.load) begin
         rem_in_v = '0;
         qd_in_v  = ld_qd;
         dvs_in   = ld_dvs;
      end else if (ctrl.step) begin
         rem_in_v = ctrl.take ? diff[CELL_W-1:0] : rem_sh;
         qd_in_v  = {qd_ff[CELL_W-2:0], qd_in};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_v;
      qd_ff  <= qd_in_v;
      dvs_ff <= dvs_in;
   end

   assign rem_msb    = rem_ff[CELL_W-1];
   assign qd_msb     = qd_ff[CELL_W-1];
   assign borrow_out = diff[CELL_W];
   assign rem        = rem_ff;
   assign qd         = qd_ff;

endmodule

/* hw/rtl/int32_divider_with_div0_rules.sv */
// Top level of the 32-bit integer divider with fixed divide-by-zero answers.
`timescale 1ns / 1ps

// This block divides two 32-bit words, unsigned (opcode 0) or signed two's
// complement (opcode 1), and returns one result word per request word with
// the quotient, the remainder and a divide-by-zero flag. A request is taken
// only while the divider is idle; a finished result sits in an output
// register, so the next request can be taken while the previous result still
// waits on rsp_ready. With a nonzero divisor the accepting edge loads the
// magnitudes, the run state then performs restoring shift-subtract for all
// 32 quotient bits (one quotient bit per edge), and the fix state applies
// the sign fixup, fills the output register and makes the divider idle
// again for the next request. The fix state waits while an earlier result
// still sits unread in the output register. The row of cells is four 8-bit
// slices that share one borrow chain, so each cycle of the run state
// retires exactly one quotient bit. A zero divisor skips the iterations and
// goes straight from acceptance to the fix state. Signed results wrap, so
// the most negative value divided by minus one gives itself with a zero
// remainder. On a zero divisor the remainder is the dividend; the quotient
// is zero for a zero dividend and otherwise all ones (unsigned), or the
// largest positive or most negative value by the dividend's sign (signed).
module int32_divider_with_div0_rules
   import i32div_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  div_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output div_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIX  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   div_rsp_type           rsp_data_ff, rsp_data_in;

   // Per-request flags captured at acceptance.
   logic                  signed_ff, signed_in;
   logic                  nneg_ff, nneg_in;
   logic                  dneg_ff, dneg_in;
   logic                  dz_ff, dz_in;
   logic [DATA_WIDTH-1:0] n_ff, n_in;

   logic                  accept;
   logic                  fix_fire;
   logic                  req_nneg, req_dneg, req_dz;
   logic [DATA_WIDTH-1:0] mag_n, mag_d;

   cell_ctrl_type         ctrl;
   logic [N_CELLS-1:0]    rem_msb, qd_msb, borrow;
   logic [N_CELLS-1:0]    rem_link, qd_link, borrow_link;
   logic [N_CELLS-1:0][CELL_W-1:0] rem_slice, qd_slice;
   logic [DATA_WIDTH-1:0] rem_all, qd_all;
   logic [DATA_WIDTH-1:0] q_res, r_res;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fix_fire  = (state_ff == ST_FIX) && (!rsp_valid_ff || rsp_ready);

   // Operand magnitudes are formed on the way into the cells.
   always_comb begin
      req_nneg = (req_data.opcode == OP_SIGNED) && req_data.dividend[DATA_WIDTH-1];
      req_dneg = (req_data.opcode == OP_SIGNED) && req_data.divisor[DATA_WIDTH-1];
      req_dz   = (req_data.divisor == '0);
      mag_n    = req_nneg ? (~req_data.dividend + DATA_WIDTH'(1)) : req_data.dividend;
      mag_d    = req_dneg ? (~req_data.divisor + DATA_WIDTH'(1)) : req_data.divisor;
   end

   // The row shifts {remainder, dividend} left as one long register. The
   // dividend bit leaving the top slice enters the remainder at the bottom,
   // and the new quotient bit enters the dividend field at the bottom. A
   // subtraction is kept when the bit shifted out of the remainder was set or
   // the shifted remainder is at least the divisor.
   always_comb begin
      ctrl.load = accept;
      ctrl.step = (state_ff == ST_RUN);
      ctrl.take = rem_msb[N_CELLS-1] || !borrow[N_CELLS-1];
      rem_link[0]    = qd_msb[N_CELLS-1];
      qd_link[0]     = ctrl.take;
      borrow_link[0] = 1'b0;
      for (int k = 1; k < N_CELLS; k++) begin
         rem_link[k]    = rem_msb[k-1];
         qd_link[k]     = qd_msb[k-1];
         borrow_link[k] = borrow[k-1];
      end
   end

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      i32div_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ld_qd      (mag_n[k*CELL_W +: CELL_W]),
         .ld_dvs     (mag_d[k*CELL_W +: CELL_W]),
         .rem_in     (rem_link[k]),
         .qd_in      (qd_link[k]),
         .borrow_in  (borrow_link[k]),
         .rem_msb    (rem_msb[k]),
         .qd_msb     (qd_msb[k]),
         .borrow_out (borrow[k]),
         .rem        (rem_slice[k]),
         .qd         (qd_slice[k])
      );
   end

   assign rem_all = rem_slice;
   assign qd_all  = qd_slice;

   // Sign fixup and the divide-by-zero answers.
   always_comb begin
      q_res = qd_all;
      r_res = rem_all;
      if (signed_ff && (nneg_ff != dneg_ff)) begin
         q_res = ~qd_all + DATA_WIDTH'(1);
      end
      if (signed_ff && nneg_ff) begin
         r_res = ~rem_all + DATA_WIDTH'(1);
      end
      if (dz_ff) begin
         r_res = n_ff;
         if (n_ff == '0) begin
            q_res = '0;
         end else if (!signed_ff) begin
            q_res = DW_ONES;
         end else if (n_ff[DATA_WIDTH-1]) begin
            q_res = DW_SIGN;
         end else begin
            q_res = DW_MAXPOS;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      signed_in    = signed_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      dz_in        = dz_ff;
      n_in         = n_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               signed_in = (req_data.opcode == OP_SIGNED);
               nneg_in   = req_nneg;
               dneg_in   = req_dneg;
               dz_in     = req_dz;
               n_in      = req_data.dividend;
               cnt_in    = '0;
               state_in  = req_dz ? ST_FIX : ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (fix_fire) begin
               rsp_data_in.quotient    = q_res;
               rsp_data_in.remainder   = r_res;
               rsp_data_in.div_by_zero = dz_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      signed_ff   <= signed_in;
      nneg_ff     <= nneg_in;
      dneg_ff     <= dneg_in;
      dz_ff       <= dz_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
